[rtl/core/i2cm_pkg.sv]
// Package for the I2C master byte engine: state, result types, phase codes and step lengths.
// No dependencies; used by all files under rtl/core.
package i2cm_pkg;

    // Phase of the bus sequencer, one-hot
    typedef enum logic [18:0] {
        PH_IDLE = 19'h00001,
        PH_S0   = 19'h00002,
        PH_S1   = 19'h00004,
        PH_S2   = 19'h00008,
        PH_S3   = 19'h00010,
        PH_P0   = 19'h00020,
        PH_P1   = 19'h00040,
        PH_P2   = 19'h00080,
        PH_W0   = 19'h00100,
        PH_W1   = 19'h00200,
        PH_W2   = 19'h00400,
        PH_W3   = 19'h00800,
        PH_W4   = 19'h01000,
        PH_W5   = 19'h02000,
        PH_R0   = 19'h04000,
        PH_R1   = 19'h08000,
        PH_A0   = 19'h10000,
        PH_A1   = 19'h20000,
        PH_A2   = 19'h40000
    } phase_t;

    // Command codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_UNIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 2'd1;

    localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd200;

    // Step lengths in delay units
    localparam logic [3:0] U_SETUP    = 4'd1;
    localparam logic [3:0] U_EDGE     = 4'd5;
    localparam logic [3:0] U_BIT      = 4'd2;
    localparam logic [3:0] U_SAMPLE   = 4'd1;
    localparam logic [3:0] U_ACK_WAIT = 4'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Largest step count: 10 units of 255 ticks
    localparam logic [11:0] WAIT_MAX = 12'd2549;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [11:0] wait_count;
        logic [7:0]  poll_count;
        logic        scl;
        logic        sda;
        logic        sda_oe;
        logic        ack_flag;
        logic        ack_mode;
        logic [7:0]  rx_hold;
    } eng_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       acked;
    } result_t;

endpackage

[rtl/core/i2c_master_byte_engine.sv]
// I2C master byte engine: one bus tick per input word, one result word per tick.
// The result of a tick is registered in the result buffer and offered behind any results still waiting there.
// Throughput: one word per cycle while the result buffer is not full; a two-word result buffer decouples the sides.
// Reset (aresetn low, synchronous): sequencer idle, SCL/SDA high and driven,
// ticks_per_unit = 1, ack_timeout = 200, result buffer empty.
// Depends on i2cm_pkg, i2cm_step and i2cm_out_buf.
module i2c_master_byte_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd_valid,
    input  logic [1:0]                         s_func,
    input  logic [7:0]                         s_tx_byte,
    input  logic                               s_send_ack,
    input  logic                               s_sda_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_scl_level,
    output logic                               m_sda_level,
    output logic                               m_sda_enable,
    output logic                               m_busy_res,
    output logic                               m_done_res,
    output logic [7:0]                         m_rx_byte,
    output logic                               m_acked,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                         cfg_data
);
    import i2cm_pkg::*;

    logic [7:0] ticks_per_unit_reg;
    logic [7:0] ack_timeout_reg;
    eng_state_t state_reg, state_next;
    result_t    step_word, out_word;
    logic       accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_unit_reg <= TICKS_PER_UNIT_RST;
            ack_timeout_reg    <= ACK_TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TICKS_PER_UNIT: ticks_per_unit_reg <= cfg_data;
                REG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cm_step u_step (
        .cur_state      (state_reg),
        .cmd_valid      (s_cmd_valid),
        .func           (s_func),
        .tx_byte        (s_tx_byte),
        .send_ack       (s_send_ack),
        .sda_sample     (s_sda_sample),
        .ticks_per_unit (ticks_per_unit_reg),
        .ack_timeout    (ack_timeout_reg),
        .next_state     (state_next),
        .result         (step_word)
    );

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bit_count  <= 4'd0;
            state_reg.shift_reg  <= 8'd0;
            state_reg.wait_count <= 12'd0;
            state_reg.poll_count <= 8'd0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
            state_reg.sda_oe     <= 1'b1;
            state_reg.ack_flag   <= 1'b0;
            state_reg.ack_mode   <= 1'b0;
            state_reg.rx_hold    <= 8'd0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    i2cm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (step_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_scl_level  = out_word.scl_level;
    assign m_sda_level  = out_word.sda_level;
    assign m_sda_enable = out_word.sda_enable;
    assign m_busy_res   = out_word.busy_res;
    assign m_done_res   = out_word.done_res;
    assign m_rx_byte    = out_word.rx_byte;
    assign m_acked      = out_word.acked;

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && state_reg.phase == PH_IDLE && !s_cmd_valid) |=> (state_reg.phase == PH_IDLE))
        else $error("sequencer left idle without a command");

    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.wait_count <= WAIT_MAX)
        else $error("step counter beyond the longest step");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && step_word.done_res) |=> (state_reg.phase == PH_IDLE))
        else $error("done reported while the sequencer still runs");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("sequencer state moved without an accepted tick");

endmodule

[rtl/core/i2cm_step.sv]
// One bus tick of the I2C master sequencer: next state and pin/status word.
// Depends on i2cm_pkg.
module i2cm_step (
    input  i2cm_pkg::eng_state_t cur_state,
    input  logic                 cmd_valid,
    input  logic [1:0]           func,
    input  logic [7:0]           tx_byte,
    input  logic                 send_ack,
    input  logic                 sda_sample,
    input  logic [7:0]           ticks_per_unit,
    input  logic [7:0]           ack_timeout,
    output i2cm_pkg::eng_state_t next_state,
    output i2cm_pkg::result_t    result
);
    import i2cm_pkg::*;

    function automatic logic [11:0] load_wait(input logic [3:0] units);
        logic [7:0]  t;
        logic [11:0] prod;
        t    = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
        prod = 12'(units) * 12'(t);
        return prod - 12'd1;
    endfunction

    // Sample SDA for the slave acknowledge; drop SCL once it ends
    function automatic eng_state_t poll_tick(input eng_state_t st);
        eng_state_t n;
        n = st;
        if (!sda_sample) begin
            n.ack_flag   = 1'b1;
            n.phase      = PH_W5;
            n.scl        = 1'b0;
            n.wait_count = load_wait(U_BIT);
        end else if (st.poll_count >= ack_timeout) begin
            n.ack_flag   = 1'b0;
            n.phase      = PH_W5;
            n.scl        = 1'b0;
            n.wait_count = load_wait(U_BIT);
        end else begin
            n.poll_count = st.poll_count + 8'd1;
        end
        return n;
    endfunction

    function automatic eng_state_t enter_phase(input eng_state_t st, input phase_t p);
        eng_state_t n;
        n = st;
        n.phase = p;
        unique case (p)
            PH_S0: begin
                n.sda_oe = 1'b1; n.sda = 1'b1; n.wait_count = load_wait(U_SETUP);
            end
            PH_S1: begin n.scl = 1'b1; n.wait_count = load_wait(U_EDGE); end
            PH_S2: begin n.sda = 1'b0; n.wait_count = load_wait(U_EDGE); end
            PH_S3: begin n.scl = 1'b0; n.wait_count = load_wait(U_EDGE); end
            PH_P0: begin
                n.sda_oe = 1'b1; n.sda = 1'b0; n.wait_count = load_wait(U_SETUP);
            end
            PH_P1: begin n.scl = 1'b1; n.wait_count = load_wait(U_EDGE); end
            PH_P2: begin n.sda = 1'b1; n.wait_count = load_wait(U_EDGE); end
            PH_W0: begin
                n.sda_oe     = 1'b1;
                n.scl        = 1'b0;
                n.sda        = st.shift_reg[7];
                n.shift_reg  = {st.shift_reg[6:0], 1'b0};
                n.wait_count = load_wait(U_BIT);
            end
            PH_W1: begin n.scl = 1'b1; n.wait_count = load_wait(U_BIT); end
            PH_W2: begin n.scl = 1'b0; n.wait_count = load_wait(U_BIT); end
            PH_W3: begin n.sda_oe = 1'b0; n.wait_count = load_wait(U_ACK_WAIT); end
            PH_W4: begin
                n.scl        = 1'b1;
                n.poll_count = 8'd0;
                n            = poll_tick(n);
            end
            PH_W5: begin n.scl = 1'b0; n.wait_count = load_wait(U_BIT); end
            PH_R0: begin
                n.sda_oe = 1'b0; n.scl = 1'b0; n.wait_count = load_wait(U_BIT);
            end
            PH_R1: begin
                n.scl        = 1'b1;
                n.shift_reg  = {st.shift_reg[6:0], sda_sample};
                n.bit_count  = st.bit_count + 4'd1;
                n.wait_count = load_wait(U_SAMPLE);
            end
            PH_A0: begin
                n.scl        = 1'b0;
                n.sda_oe     = 1'b1;
                n.sda        = ~st.ack_mode;
                n.wait_count = load_wait(U_BIT);
            end
            PH_A1: begin n.scl = 1'b1; n.wait_count = load_wait(U_BIT); end
            PH_A2: begin n.scl = 1'b0; n.phase = PH_IDLE; end
            default: n.phase = PH_IDLE;
        endcase
        return n;
    endfunction

    // Move to the following step once the current one has run out
    function automatic eng_state_t advance(input eng_state_t st);
        eng_state_t n;
        n = st;
        unique case (st.phase)
            PH_S0: n = enter_phase(st, PH_S1);
            PH_S1: n = enter_phase(st, PH_S2);
            PH_S2: n = enter_phase(st, PH_S3);
            PH_P0: n = enter_phase(st, PH_P1);
            PH_P1: n = enter_phase(st, PH_P2);
            PH_W0: n = enter_phase(st, PH_W1);
            PH_W1: n = enter_phase(st, PH_W2);
            PH_W2: begin
                n.bit_count = st.bit_count + 4'd1;
                n = enter_phase(n, (n.bit_count >= BITS_PER_BYTE) ? PH_W3 : PH_W0);
            end
            PH_W3: n = enter_phase(st, PH_W4);
            PH_R0: n = enter_phase(st, PH_R1);
            PH_R1: begin
                if (st.bit_count >= BITS_PER_BYTE) begin
                    n.rx_hold = st.shift_reg;
                    n = enter_phase(n, PH_A0);
                end else begin
                    n = enter_phase(st, PH_R0);
                end
            end
            PH_A0: n = enter_phase(st, PH_A1);
            PH_A1: n = enter_phase(st, PH_A2);
            default: n.phase = PH_IDLE;
        endcase
        return n;
    endfunction

    eng_state_t st_next;

    always_comb begin
        st_next = cur_state;
        if (cur_state.phase == PH_IDLE) begin
            if (cmd_valid) begin
                st_next.bit_count  = 4'd0;
                st_next.poll_count = 8'd0;
                st_next.shift_reg  = 8'd0;
                unique case (func)
                    FUNC_START: st_next = enter_phase(st_next, PH_S0);
                    FUNC_STOP:  st_next = enter_phase(st_next, PH_P0);
                    FUNC_WRITE: begin
                        st_next.shift_reg = tx_byte;
                        st_next = enter_phase(st_next, PH_W0);
                    end
                    FUNC_READ: begin
                        st_next.ack_mode = send_ack;
                        st_next = enter_phase(st_next, PH_R0);
                    end
                endcase
            end
        end else if (cur_state.phase == PH_W4) begin
            st_next = poll_tick(cur_state);
        end else if (cur_state.wait_count != 12'd0) begin
            st_next.wait_count = cur_state.wait_count - 12'd1;
        end else begin
            st_next = advance(cur_state);
        end
    end

    assign next_state = st_next;

    always_comb begin
        result.scl_level  = st_next.scl;
        result.sda_level  = st_next.sda;
        result.sda_enable = st_next.sda_oe;
        result.busy_res   = (st_next.phase != PH_IDLE);
        // Only a running command can fall back to idle
        result.done_res   = (cur_state.phase != PH_IDLE) && (st_next.phase == PH_IDLE);
        result.rx_byte    = st_next.rx_hold;
        result.acked      = st_next.ack_flag;
    end

endmodule

[rtl/core/i2cm_out_buf.sv]
// Two-word result buffer: keeps the input side moving while a result waits.
// Depends on i2cm_pkg.
module i2cm_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cm_pkg::result_t in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cm_pkg::result_t out_word
);
    import i2cm_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = slot0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({push, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    slot0_next = in_word;
                end else begin
                    slot1_next = in_word;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b11: begin
                // advance the head and refill behind it
                if (cnt_reg == 2'd1) begin
                    slot0_next = in_word;
                end else begin
                    slot0_next = slot1_reg;
                    slot1_next = in_word;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_shift_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && pop) |=> (slot0_reg == $past(slot1_reg)))
        else $error("result buffer head not advanced");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && push) |=> (out_valid && slot0_reg == $past(in_word)))
        else $error("result buffer lost a word into an empty buffer");

endmodule
